### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

### hw/rtl/sscx_pkg.sv
package sscx_pkg;

    // Lexer modes
    typedef enum logic [2:0] {
        MODE_CODE    = 3'd0,
        MODE_DQ      = 3'd1,
        MODE_SQ      = 3'd2,
        MODE_LINE    = 3'd3,
        MODE_DASHES  = 3'd4,
        MODE_BRACKET = 3'd5,
        MODE_BLOCK   = 3'd6
    } mode_t;

    // Event kinds toward the message buffer
    typedef enum logic [1:0] {
        EV_CLEAR  = 2'd0,
        EV_APPEND = 2'd1,
        EV_COMMIT = 2'd2
    } ev_kind_t;

    localparam int EV_LINE_W = 20;
    localparam int HIST_DEPTH = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_NAME_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_HIGH = 2'd1;

    // Character codes
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef logic [HIST_DEPTH-1:0][7:0] name_bytes_t;

    // One lexer decision for one byte
    typedef struct packed {
        logic                 emit;
        ev_kind_t             kind;
        logic [7:0]           text;
        logic [EV_LINE_W-1:0] line;
    } ev_t;

endpackage

### hw/rtl/sscx_lexer.sv
module sscx_lexer #(
    parameter int NAME_LEN   = 9,
    parameter int LINE_WIDTH = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           byte_in,
    input  logic                 chunk_in,
    input  sscx_pkg::name_bytes_t name_bytes,
    output sscx_pkg::ev_t        ev
);
    import sscx_pkg::*;

    mode_t                 mode_reg, mode_next, cur_mode;
    logic [7:0]            hist_reg [HIST_DEPTH];
    logic [7:0]            hist_cur [HIST_DEPTH];
    logic [3:0]            fill_reg, fill_cur;
    logic [LINE_WIDTH-1:0] line_reg, line_cur, line_next;
    logic [LINE_WIDTH-1:0] marker_reg, marker_cur, marker_next;
    logic                  restart_reg, restart_cur, restart_next;
    logic                  inside_reg, inside_cur, inside_next;
    logic                  sealed_reg, sealed_cur, sealed_next;
    logic [NAME_LEN-1:0]   hit;
    logic                  name_hit;
    logic [31:0]           marker_wide;
    logic [7:0]            b, p1, p2, p3;

    // Apply chunk restart ahead of the scan
    always_comb
    begin
        cur_mode    = chunk_in ? MODE_CODE : mode_reg;
        fill_cur    = chunk_in ? 4'd0 : fill_reg;
        line_cur    = chunk_in ? LINE_WIDTH'(1) : line_reg;
        marker_cur  = chunk_in ? LINE_WIDTH'(1) : marker_reg;
        restart_cur = chunk_in ? 1'b1 : restart_reg;
        inside_cur  = chunk_in ? 1'b0 : inside_reg;
        sealed_cur  = chunk_in ? 1'b0 : sealed_reg;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            hist_cur[i] = chunk_in ? 8'h00 : hist_reg[i];
        end
    end

    assign b  = byte_in;
    assign p1 = hist_cur[0];
    assign p2 = hist_cur[1];
    assign p3 = hist_cur[2];

    // Compare history against the marker name, most recent byte last in the name
    for (genvar g = 0; g < NAME_LEN; g++)
    begin : g_cmp
        assign hit[g] = (hist_cur[g] == name_bytes[NAME_LEN-1-g]);
    end
    assign name_hit = (&hit) && (fill_cur >= 4'(NAME_LEN));

    assign marker_wide = 32'(marker_cur);

    // Next lexer state and event
    always_comb
    begin
        mode_next    = cur_mode;
        restart_next = restart_cur;
        inside_next  = inside_cur;
        sealed_next  = sealed_cur;
        marker_next  = marker_cur;
        ev.emit      = 1'b0;
        ev.kind      = EV_CLEAR;
        ev.text      = 8'h00;
        ev.line      = '0;
        unique case (cur_mode) inside
            MODE_DQ, MODE_SQ:
            begin
                if (p1 == CH_BSLASH)
                begin
                    ev.emit = 1'b1;
                    ev.kind = EV_APPEND;
                    ev.text = (b == CH_N) ? CH_LF : ((b == CH_T) ? CH_TAB : b);
                end
                else if ((cur_mode == MODE_DQ && b == CH_DQUOTE) ||
                         (cur_mode == MODE_SQ && b == CH_SQUOTE))
                begin
                    mode_next    = MODE_CODE;
                    restart_next = 1'b1;
                end
                else if (b != CH_BSLASH)
                begin
                    ev.emit = 1'b1;
                    ev.kind = EV_APPEND;
                    ev.text = b;
                end
                // Drop appends once the message is sealed
                if (ev.emit && sealed_cur)
                begin
                    ev.emit = 1'b0;
                    ev.text = 8'h00;
                end
            end
            MODE_LINE:
            begin
                if (b == CH_LF)
                begin
                    mode_next = MODE_CODE;
                end
            end
            MODE_DASHES, MODE_BRACKET:
            begin
                if (b == CH_LBRACK)
                begin
                    mode_next = (cur_mode == MODE_DASHES) ? MODE_BRACKET : MODE_BLOCK;
                end
                else if (b == CH_LF)
                begin
                    mode_next = MODE_CODE;
                end
                else
                begin
                    mode_next = MODE_LINE;
                end
            end
            MODE_BLOCK:
            begin
                if (p3 == CH_RBRACK && p2 == CH_RBRACK && p1 == CH_DASH && b == CH_DASH)
                begin
                    mode_next = MODE_CODE;
                end
            end
            default:
            begin
                // Code mode; the unused code behaves the same
                mode_next = MODE_CODE;
                if (b == CH_LPAREN)
                begin
                    if (name_hit)
                    begin
                        inside_next = 1'b1;
                        marker_next = line_cur;
                    end
                end
                else if (b == CH_RPAREN)
                begin
                    if (inside_cur)
                    begin
                        inside_next = 1'b0;
                        sealed_next = 1'b1;
                        ev.emit     = 1'b1;
                        ev.kind     = EV_COMMIT;
                        ev.line     = marker_wide[EV_LINE_W-1:0];
                    end
                end
                else if (p1 == CH_DOT && b == CH_DOT)
                begin
                    restart_next = 1'b0;
                end
                else if (b == CH_DQUOTE || b == CH_SQUOTE)
                begin
                    mode_next = (b == CH_DQUOTE) ? MODE_DQ : MODE_SQ;
                    if (restart_cur)
                    begin
                        sealed_next = 1'b0;
                        ev.emit     = 1'b1;
                        ev.kind     = EV_CLEAR;
                    end
                end
                else if (p1 == CH_DASH && b == CH_DASH)
                begin
                    mode_next = MODE_DASHES;
                end
            end
        endcase
    end

    // Count lines, saturating
    assign line_next = (b == CH_LF && line_cur != '1) ? line_cur + LINE_WIDTH'(1) : line_cur;

    // Advance state on each scanned byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_CODE;
            fill_reg    <= 4'd0;
            line_reg    <= LINE_WIDTH'(1);
            marker_reg  <= LINE_WIDTH'(1);
            restart_reg <= 1'b1;
            inside_reg  <= 1'b0;
            sealed_reg  <= 1'b0;
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= 8'h00;
            end
        end
        else if (step)
        begin
            mode_reg    <= mode_next;
            fill_reg    <= (fill_cur < 4'(HIST_DEPTH)) ? fill_cur + 4'd1 : fill_cur;
            line_reg    <= line_next;
            marker_reg  <= marker_next;
            restart_reg <= restart_next;
            inside_reg  <= inside_next;
            sealed_reg  <= sealed_next;
            hist_reg[0] <= b;
            for (int i = 1; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= hist_cur[i-1];
            end
        end
    end

endmodule

### hw/rtl/script_string_call_extractor.sv
// Throughput: one byte per cycle unless out_ready stalls the result stage.
// Beats pass input stage, lexer state loop (single registered pass), result stage.
// A byte that yields no event produces no result beat.
// Reset (rst_n, asynchronous, active low) clears the lexer to code mode, line 1,
// empty history, both pipeline stages empty and the call name registers to zero.
`include "assert_macros.svh"

module script_string_call_extractor #(
    parameter int NAME_LEN   = 9,
    parameter int LINE_WIDTH = 20
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         source_byte,
    input  logic                               chunk_start,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         event_kind,
    output logic [7:0]                         text_byte,
    output logic [sscx_pkg::EV_LINE_W-1:0]     call_line,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sscx_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [63:0]                        cfg_data
);
    import sscx_pkg::*;

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_chunk_reg;
    logic                 out_valid_reg;
    ev_kind_t             out_kind_reg;
    logic [7:0]           out_text_reg;
    logic [EV_LINE_W-1:0] out_line_reg;
    logic [63:0]          name_low_reg;
    logic [7:0]           name_high_reg;
    name_bytes_t          name_bytes;
    ev_t                  ev;
    logic                 advance;
    logic                 step;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_low_reg  <= 64'd0;
            name_high_reg <= 8'd0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_NAME_LOW)
            begin
                name_low_reg <= cfg_data;
            end
            else if (cfg_index == REG_NAME_HIGH)
            begin
                name_high_reg <= cfg_data[7:0];
            end
        end
    end

    // Unpack the name, first byte in the top bits of the low register
    always_comb
    begin
        for (int i = 0; i < HIST_DEPTH - 1; i++)
        begin
            name_bytes[i] = name_low_reg[63 - 8*i -: 8];
        end
        name_bytes[HIST_DEPTH-1] = name_high_reg;
    end

    // Pipeline control
    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    // Input stage: hold the beat until the lexer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg  <= source_byte;
            in_chunk_reg <= chunk_start;
        end
    end

    sscx_lexer #(
        .NAME_LEN   (NAME_LEN),
        .LINE_WIDTH (LINE_WIDTH)
    ) u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .byte_in    (in_byte_reg),
        .chunk_in   (in_chunk_reg),
        .name_bytes (name_bytes),
        .ev         (ev)
    );

    // Result stage: load an event beat, hold it while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && ev.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && ev.emit)
        begin
            out_kind_reg <= ev.kind;
            out_text_reg <= ev.text;
            out_line_reg <= ev.line;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = out_kind_reg;
    assign text_byte  = out_text_reg;
    assign call_line  = out_line_reg;

    `ASSERT_SAME(a_text_only_append, clk, rst_n,
        out_valid_reg && out_kind_reg != EV_APPEND, out_text_reg == 8'h00)
    `ASSERT_SAME(a_line_only_commit, clk, rst_n,
        out_valid_reg && out_kind_reg != EV_COMMIT, out_line_reg == '0)
    `ASSERT_NEXT(a_input_stage_holds, clk, rst_n,
        in_valid_reg && !advance, in_valid_reg && $stable(in_byte_reg))
    `ASSERT_SAME(a_stall_only_when_full, clk, rst_n,
        !in_ready, in_valid_reg && out_valid_reg)

endmodule

### verif/tb_script_string_call_extractor.sv
module tb_script_string_call_extractor;

    import sscx_pkg::*;

    // One source byte as offered to the block
    typedef struct {
        logic [7:0] b;
        logic       cs;
    } src_beat_t;

    // One event toward the message buffer
    typedef struct {
        ev_kind_t             kind;
        logic [7:0]           text;
        logic [EV_LINE_W-1:0] line;
    } lex_event_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [7:0]           source_byte = 8'h00;
    logic                 chunk_start = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [1:0]           event_kind;
    logic [7:0]           text_byte;
    logic [EV_LINE_W-1:0] call_line;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = '0;

    src_beat_t  script_q[$];
    lex_event_t lex_events[$];
    src_beat_t  cur_beat;
    int         fed_beats = 0;
    int         error_count = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    bit         chunk_next = 1'b0;

    // Scanner copy: call name and lexer state
    logic [63:0]          name_lo = '0;
    logic [7:0]           name_hi = '0;
    mode_t                lex_mode = MODE_CODE;
    logic [7:0]           hist [HIST_DEPTH];
    int                   fill = 0;
    logic [EV_LINE_W-1:0] line_no = 1;
    logic [EV_LINE_W-1:0] call_start_line = 1;
    bit                   restart = 1'b1;
    bit                   in_call = 1'b0;
    bit                   sealed = 1'b0;

    script_string_call_extractor DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .source_byte (source_byte),
        .chunk_start (chunk_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .text_byte   (text_byte),
        .call_line   (call_line),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] name_at(input int i);
        if (i >= 8)
            return name_hi;
        return name_lo[63 - 8 * i -: 8];
    endfunction

    // Return the scanner to code mode, line 1, empty history
    function automatic void restart_scan();
        lex_mode = MODE_CODE;
        for (int k = 0; k < HIST_DEPTH; k++)
            hist[k] = 8'h00;
        fill = 0;
        line_no = 1;
        call_start_line = 1;
        restart = 1'b1;
        in_call = 1'b0;
        sealed = 1'b0;
    endfunction

    function automatic bit name_hit();
        if (fill < HIST_DEPTH)
            return 1'b0;
        for (int k = 0; k < HIST_DEPTH; k++)
            if (hist[k] != name_at(HIST_DEPTH - 1 - k))
                return 1'b0;
        return 1'b1;
    endfunction

    // Advance the scanner by one byte and queue the event it yields
    function automatic void scan_beat(input src_beat_t sb);
        logic [7:0] b;
        logic [7:0] p1;
        logic [7:0] p2;
        logic [7:0] p3;
        bit         emit;
        lex_event_t ev;
        b = sb.b;
        emit = 1'b0;
        ev.kind = EV_CLEAR;
        ev.text = 8'h00;
        ev.line = '0;
        if (sb.cs)
            restart_scan();
        p1 = hist[0];
        p2 = hist[1];
        p3 = hist[2];
        case (lex_mode)
            MODE_DQ, MODE_SQ:
            begin
                if (p1 == CH_BSLASH)
                begin
                    ev.kind = EV_APPEND;
                    ev.text = (b == CH_N) ? CH_LF : ((b == CH_T) ? CH_TAB : b);
                    emit = 1'b1;
                end
                else if ((lex_mode == MODE_DQ && b == CH_DQUOTE) ||
                         (lex_mode == MODE_SQ && b == CH_SQUOTE))
                begin
                    lex_mode = MODE_CODE;
                    restart = 1'b1;
                end
                else if (b != CH_BSLASH)
                begin
                    ev.kind = EV_APPEND;
                    ev.text = b;
                    emit = 1'b1;
                end
                // drop appends after a commit until the next clear
                if (sealed)
                    emit = 1'b0;
            end
            MODE_LINE:
            begin
                if (b == CH_LF)
                    lex_mode = MODE_CODE;
            end
            MODE_DASHES, MODE_BRACKET:
            begin
                if (b == CH_LBRACK)
                begin
                    if (lex_mode == MODE_DASHES)
                        lex_mode = MODE_BRACKET;
                    else
                        lex_mode = MODE_BLOCK;
                end
                else if (b == CH_LF)
                    lex_mode = MODE_CODE;
                else
                    lex_mode = MODE_LINE;
            end
            MODE_BLOCK:
            begin
                if (p3 == CH_RBRACK && p2 == CH_RBRACK && p1 == CH_DASH && b == CH_DASH)
                    lex_mode = MODE_CODE;
            end
            default:
            begin
                lex_mode = MODE_CODE;
                if (b == CH_LPAREN)
                begin
                    if (name_hit())
                    begin
                        in_call = 1'b1;
                        call_start_line = line_no;
                    end
                end
                else if (b == CH_RPAREN)
                begin
                    if (in_call)
                    begin
                        in_call = 1'b0;
                        sealed = 1'b1;
                        ev.kind = EV_COMMIT;
                        ev.line = call_start_line;
                        emit = 1'b1;
                    end
                end
                else if (p1 == CH_DOT && b == CH_DOT)
                    restart = 1'b0;
                else if (b == CH_DQUOTE || b == CH_SQUOTE)
                begin
                    if (b == CH_DQUOTE)
                        lex_mode = MODE_DQ;
                    else
                        lex_mode = MODE_SQ;
                    if (restart)
                    begin
                        sealed = 1'b0;
                        emit = 1'b1;
                    end
                end
                else if (p1 == CH_DASH && b == CH_DASH)
                    lex_mode = MODE_DASHES;
            end
        endcase
        for (int k = HIST_DEPTH - 1; k > 0; k--)
            hist[k] = hist[k - 1];
        hist[0] = b;
        if (fill < HIST_DEPTH)
            fill++;
        if (b == CH_LF && line_no != '1)
            line_no++;
        if (emit)
            lex_events.push_back(ev);
    endfunction

    // Source side: offer queued bytes, predict on each accepted beat
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                scan_beat(cur_beat);
            if (!in_valid || in_ready)
            begin
                if (script_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_beat = script_q.pop_front();
                    source_byte <= cur_beat.b;
                    chunk_start <= cur_beat.cs;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: check each result beat against the oldest expected event
    always @(posedge clk)
    begin
        lex_event_t exp_ev;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (lex_events.size() == 0)
                begin
                    $error("unexpected result beat: event_kind %0d text_byte %0h call_line %0d",
                           event_kind, text_byte, call_line);
                    error_count++;
                end
                else
                begin
                    exp_ev = lex_events.pop_front();
                    if (event_kind !== exp_ev.kind)
                    begin
                        $error("event_kind: expected %0d, got %0d", exp_ev.kind, event_kind);
                        error_count++;
                    end
                    if (text_byte !== exp_ev.text)
                    begin
                        $error("text_byte: expected %0h, got %0h", exp_ev.text, text_byte);
                        error_count++;
                    end
                    if (call_line !== exp_ev.line)
                    begin
                        $error("call_line: expected %0d, got %0d", exp_ev.line, call_line);
                        error_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void feed_byte(input logic [7:0] b);
        src_beat_t sb;
        sb.b = b;
        sb.cs = chunk_next;
        chunk_next = 1'b0;
        script_q.push_back(sb);
        fed_beats++;
    endfunction

    function automatic void feed_text(input string s);
        for (int i = 0; i < s.len(); i++)
            feed_byte(s[i]);
    endfunction

    // Push name bytes from index first on, corrupting one byte if flip is in range
    function automatic void feed_name(input int first, input int flip);
        logic [7:0] b;
        for (int i = first; i < HIST_DEPTH; i++)
        begin
            b = name_at(i);
            if (i == flip)
                b = b ^ 8'($urandom_range(1, 255));
            feed_byte(b);
        end
    endfunction

    // Quoted literal with random content and escapes
    function automatic void feed_literal();
        logic [7:0] q;
        logic [7:0] c;
        int         n;
        q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
        n = $urandom_range(8);
        feed_byte(q);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0:
                begin
                    feed_byte(CH_BSLASH);
                    case ($urandom_range(5))
                        0: feed_byte(CH_N);
                        1: feed_byte(CH_T);
                        2: feed_byte(CH_BSLASH);
                        3: feed_byte(q);
                        4: feed_byte(CH_DQUOTE ^ CH_SQUOTE ^ q);
                        default: feed_byte(8'($urandom_range(255)));
                    endcase
                end
                1:
                begin
                    do
                        c = 8'($urandom_range(255));
                    while (c == q || c == CH_BSLASH);
                    feed_byte(c);
                end
                2: feed_byte(CH_LF);
                default: feed_byte(8'($urandom_range(97, 122)));
            endcase
        end
        feed_byte(q);
    endfunction

    // Argument list: zero to three literals joined by '..'
    function automatic void feed_call_args();
        int n;
        n = $urandom_range(3);
        feed_byte(CH_LPAREN);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
            begin
                feed_text($urandom_range(1) ? ".." : " ..\n ");
            end
            feed_literal();
        end
        feed_byte(CH_RPAREN);
        if ($urandom_range(3) == 0)
        begin
            feed_text("..");
            feed_literal();
        end
        if ($urandom_range(1))
            feed_byte(CH_LF);
    endfunction

    task automatic gen_script(input int n_beats);
        int stop_at;
        int pick;
        int n;
        stop_at = fed_beats + n_beats;
        while (fed_beats < stop_at)
        begin
            if ($urandom_range(99) < 4)
                chunk_next = 1'b1;
            pick = $urandom_range(99);
            if (pick < 32)
            begin
                // marker call
                if ($urandom_range(3) == 0)
                    feed_byte(8'h20);
                feed_name(0, -1);
                feed_call_args();
            end
            else if (pick < 38)
            begin
                // name with one wrong byte
                feed_name(0, $urandom_range(8));
                feed_call_args();
            end
            else if (pick < 42)
            begin
                // name cut short at the start of a chunk
                chunk_next = 1'b1;
                feed_name($urandom_range(1, 9), -1);
                feed_call_args();
            end
            else if (pick < 50)
            begin
                feed_text("x = ");
                feed_literal();
                feed_byte(CH_LF);
            end
            else if (pick < 58)
            begin
                // line comment
                feed_text("--");
                feed_byte(8'($urandom_range(97, 122)));
                n = $urandom_range(10);
                for (int i = 0; i < n; i++)
                    feed_byte(8'($urandom_range(32, 126)));
                feed_byte(CH_LF);
            end
            else if (pick < 66)
            begin
                // block comment with near-terminators inside
                feed_text("--[[");
                n = $urandom_range(12);
                for (int i = 0; i < n; i++)
                begin
                    case ($urandom_range(9))
                        0, 1: feed_byte(CH_RBRACK);
                        2: feed_byte(CH_DASH);
                        3: feed_byte(CH_LF);
                        default: feed_byte(8'($urandom_range(32, 126)));
                    endcase
                end
                feed_text("]]--");
            end
            else if (pick < 72)
            begin
                case ($urandom_range(4))
                    0: feed_text("--[x)\n");
                    1: feed_text("--\n");
                    2: feed_text("-x-");
                    3: feed_text("--[\n");
                    default: feed_text("-- [[ ]]--\n");
                endcase
            end
            else if (pick < 84)
            begin
                // raw noise
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    feed_byte(8'($urandom_range(255)));
            end
            else
            begin
                case ($urandom_range(7))
                    0: feed_byte(CH_LF);
                    1: feed_byte(8'h20);
                    2: feed_text("y = 1\n");
                    3: feed_byte(CH_RPAREN);
                    4: feed_byte(CH_LPAREN);
                    5: feed_text("a.b");
                    6: feed_text("end\n");
                    default: feed_text("..");
                endcase
            end
        end
    endtask

    // Wait until every byte is taken and every event seen, then let the pipe empty
    task automatic drain();
        do
            @(negedge clk);
        while (script_q.size() != 0 || in_valid || lex_events.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_NAME_LOW)
            name_lo = val;
        else if (idx == REG_NAME_HIGH)
            name_hi = val[7:0];
    endtask

    task automatic write_name(input logic [63:0] lo, input logic [7:0] hi);
        write_reg(REG_NAME_LOW, lo);
        write_reg(REG_NAME_HIGH, {$urandom, 24'($urandom), hi});
    endtask

    initial
    begin
        logic [63:0] rnd_lo;
        for (int k = 0; k < HIST_DEPTH; k++)
            hist[k] = 8'h00;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all-zero name out of reset
        send_idle_pct = 0;
        stall_pct = 0;
        chunk_next = 1'b1;
        gen_script(150);
        drain();

        // escapes, escaped backslash before a quote, join, commit, sealed appends
        write_name("translat", "e");
        chunk_next = 1'b1;
        feed_text("translate(\"\\n\\t\\\\\\\"\"..\"x\")..'q'");
        gen_script(320);
        drain();

        // all-ones name, sender mostly idle
        send_idle_pct = 70;
        write_name('1, 8'hFF);
        chunk_next = 1'b1;
        gen_script(250);
        drain();

        // random letter name, receiver mostly stalled
        send_idle_pct = 0;
        stall_pct = 70;
        for (int i = 0; i < 8; i++)
            rnd_lo[63 - 8 * i -: 8] = 8'($urandom_range(97, 122));
        write_name(rnd_lo, 8'($urandom_range(97, 122)));
        chunk_next = 1'b1;
        gen_script(300);
        drain();

        // light idling on both sides, with a full pause midway
        send_idle_pct = 9;
        stall_pct = 9;
        write_name("localize", "_");
        chunk_next = 1'b1;
        gen_script(130);
        drain();
        gen_script(140);
        drain();

        if (error_count == 0)
            $display("** script_string_call_extractor: PASSED **");
        else
            $display("** script_string_call_extractor: FAILED **");
        $finish;
    end

    initial
    begin
        #(12 * 400000);
        $display("** script_string_call_extractor: FAILED **");
        $finish;
    end

endmodule
